FILE: src/recurrence_term_by_matrix_power_assert.svh
// assertion macros shared by the recurrence term block
// included by the files that check their own logic, no other dependencies
`ifndef RECURRENCE_TERM_BY_MATRIX_POWER_ASSERT_SVH
`define RECURRENCE_TERM_BY_MATRIX_POWER_ASSERT_SVH

`ifndef SYNTH

// property that must hold in the same cycle
`define RTBMP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define RTBMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RTBMP_ASSERT(lbl, clk, rst_n, prop, msg)
`define RTBMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: src/rtbmp_pkg.sv
// shared types and constants of the recurrence term block
// used by the modular unit, the sequencer and the top level
package rtbmp_pkg;

  // field widths
  localparam int unsigned A_BITS     = 16;
  localparam int unsigned B_BITS     = 32;
  localparam int unsigned IDX_BITS   = 32;
  localparam int unsigned M_BITS     = 16;
  localparam int unsigned OUT_BITS   = 16;

  // internal value and exponent widths
  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned EXP_BITS   = 32;

  // multiplier operand width: wide enough for the radicand
  localparam int unsigned WIDE_BITS  = B_BITS;
  localparam int unsigned CNT_BITS   = $clog2(WIDE_BITS);

  typedef logic [VALUE_BITS-1:0]         value_t;
  typedef logic [EXP_BITS-1:0]           exp_t;
  typedef logic [WIDE_BITS-1:0]          wide_t;
  typedef logic [3:0][VALUE_BITS-1:0]    mat_t;

  // modular unit operations
  typedef enum logic [1:0] {
    OP_MUL,
    OP_ADD,
    OP_SUB
  } op_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_LOOP,
    ST_COPY,
    ST_DONE
  } state_e;

  // work phases
  typedef enum logic [1:0] {
    PH_PREP,
    PH_MAT,
    PH_FIN
  } phase_e;

  // setup steps: reduce inputs, build companion matrix and second term
  typedef enum logic [2:0] {
    PS_BMOD,
    PS_AMOD,
    PS_S1,
    PS_ASQ,
    PS_COEF,
    PS_S2MUL,
    PS_S2ADD1,
    PS_S2ADD2
  } prep_step_e;

  // steps of one dot product
  typedef enum logic [1:0] {
    TM_FIRST,
    TM_SECOND,
    TM_SUM
  } term_e;

  // request from the sequencer to the modular unit
  typedef struct packed {
    logic   start;
    op_e    op;
    logic   wide;
    wide_t  x;
    value_t y;
    value_t modulus;
  } req_t;

  // response of the modular unit
  typedef struct packed {
    logic   done;
    value_t result;
  } rsp_t;

  // sequencer status toward the handshake logic
  typedef struct packed {
    logic idle;
    logic res_valid;
  } stat_t;

endpackage

FILE: src/rtbmp_modunit.sv
// shared modular arithmetic unit: bit-serial x*y mod m, plus single-step add and sub mod m
// depends on rtbmp_pkg
`include "recurrence_term_by_matrix_power_assert.svh"

module rtbmp_modunit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rtbmp_pkg::req_t req_i,
  output rtbmp_pkg::rsp_t rsp_o
);
  import rtbmp_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  wide_t                 x_q, x_d;
  value_t                y_q, y_d;
  value_t                r_q, r_d;
  value_t                res_q, res_d;

  logic [VALUE_BITS+1:0] mul_t;
  logic [VALUE_BITS+1:0] mul_red;
  logic [VALUE_BITS+1:0] two_m;
  logic [VALUE_BITS+1:0] one_m;
  logic [VALUE_BITS:0]   sum_t;
  logic [VALUE_BITS:0]   diff_t;
  value_t                r_next;
  value_t                add_res;
  value_t                sub_res;

  // one interleaved step: r = 2r + bit*y, then bring back below m
  always_comb begin
    two_m   = {1'b0, req_i.modulus, 1'b0};
    one_m   = {2'b00, req_i.modulus};
    mul_t   = {1'b0, r_q, 1'b0} + (x_q[WIDE_BITS-1] ? {2'b00, y_q} : '0);
    if (mul_t >= two_m) begin
      mul_red = mul_t - two_m;
    end else if (mul_t >= one_m) begin
      mul_red = mul_t - one_m;
    end else begin
      mul_red = mul_t;
    end
    r_next  = mul_red[VALUE_BITS-1:0];
  end

  // add and subtract mod m, operands already reduced
  always_comb begin
    sum_t  = {1'b0, req_i.x[VALUE_BITS-1:0]} + {1'b0, req_i.y};
    diff_t = {1'b0, req_i.x[VALUE_BITS-1:0]} - {1'b0, req_i.y};
    if (sum_t >= {1'b0, req_i.modulus}) begin
      add_res = value_t'(sum_t - {1'b0, req_i.modulus});
    end else begin
      add_res = sum_t[VALUE_BITS-1:0];
    end
    if (diff_t[VALUE_BITS]) begin
      sub_res = value_t'(diff_t + {1'b0, req_i.modulus});
    end else begin
      sub_res = diff_t[VALUE_BITS-1:0];
    end
  end

  // operation control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    r_d    = r_q;
    res_d  = res_q;
    if (req_i.start) begin
      unique case (req_i.op)
        OP_MUL: begin
          busy_d = 1'b1;
          x_d    = req_i.wide ? req_i.x : (req_i.x << (WIDE_BITS - VALUE_BITS));
          cnt_d  = req_i.wide ? CNT_BITS'(WIDE_BITS - 1) : CNT_BITS'(VALUE_BITS - 1);
          y_d    = req_i.y;
          r_d    = '0;
        end
        OP_ADD: begin
          done_d = 1'b1;
          res_d  = add_res;
        end
        OP_SUB: begin
          done_d = 1'b1;
          res_d  = sub_res;
        end
        default: begin
          done_d = 1'b1;
          res_d  = '0;
        end
      endcase
    end else if (busy_q) begin
      r_d   = r_next;
      x_d   = x_q << 1;
      cnt_d = cnt_q - CNT_BITS'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = r_next;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    r_q   <= r_d;
    res_q <= res_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

  `RTBMP_ASSERT(a_start_when_free, clk_i, rst_ni, !req_i.start || (!busy_q && !done_q), "request while unit busy")
  `RTBMP_ASSERT(a_result_reduced, clk_i, rst_ni, !done_q || (res_q < req_i.modulus), "unit result not below modulus")

endmodule

FILE: src/rtbmp_seq.sv
// sequencer: setup of the companion matrix, square-and-multiply loop and final dot product
// depends on rtbmp_pkg; drives the shared modular unit through req_t and rsp_t
`include "recurrence_term_by_matrix_power_assert.svh"

module rtbmp_seq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [rtbmp_pkg::A_BITS-1:0]        base_a_i,
  input  logic [rtbmp_pkg::B_BITS-1:0]        radicand_b_i,
  input  logic [rtbmp_pkg::IDX_BITS-1:0]      term_index_i,
  input  logic [rtbmp_pkg::M_BITS-1:0]        modulus_i,
  input  logic                                take_i,
  output rtbmp_pkg::stat_t                    stat_o,
  output rtbmp_pkg::value_t                   result_o,
  output rtbmp_pkg::req_t                     req_o,
  input  rtbmp_pkg::rsp_t                     rsp_i
);
  import rtbmp_pkg::*;

  state_e               state_q, state_d;
  phase_e               phase_q;
  prep_step_e           step_q;
  term_e                term_q;
  logic [1:0]           elem_q;
  logic                 sq_q;

  logic [A_BITS-1:0]    a_q;
  logic [B_BITS-1:0]    b_q;
  logic [IDX_BITS-1:0]  n_q;
  value_t               m_q;
  value_t               one_q;
  logic                 n_le1_q;
  value_t               amod_q;
  value_t               bmod_q;
  value_t               s1_q;
  value_t               s2_q;
  value_t               acc_q;
  value_t               tmp_q;
  value_t               result_q;
  exp_t                 exp_q;
  mat_t                 p_q;
  mat_t                 q_q;
  mat_t                 t_q;

  value_t               m_in;
  mat_t                 left_mat;
  value_t               left_val;
  value_t               right_val;

  assign m_in = value_t'(modulus_i);

  // matrix operands: left row from product or power matrix, right column from power
  always_comb begin
    left_mat  = sq_q ? p_q : q_q;
    left_val  = left_mat[{elem_q[1], term_q[0]}];
    right_val = p_q[{term_q[0], elem_q[0]}];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = (m_in == '0) ? ST_DONE : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (rsp_i.done) begin
          unique case (phase_q)
            PH_PREP: begin
              if (step_q == PS_S1 && n_le1_q) begin
                state_d = ST_DONE;
              end else if (step_q == PS_S2ADD2) begin
                state_d = ST_LOOP;
              end else begin
                state_d = ST_ISSUE;
              end
            end
            PH_MAT: begin
              state_d = (term_q == TM_SUM && elem_q == '1) ? ST_COPY : ST_ISSUE;
            end
            PH_FIN: begin
              state_d = (term_q == TM_SUM) ? ST_DONE : ST_ISSUE;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_LOOP: begin
        state_d = ST_ISSUE;
      end
      ST_COPY: begin
        state_d = sq_q ? ST_LOOP : ST_ISSUE;
      end
      ST_DONE: begin
        if (take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs: unit request and status
  always_comb begin
    req_o.start   = (state_q == ST_ISSUE);
    req_o.modulus = m_q;
    req_o.op      = OP_MUL;
    req_o.wide    = 1'b0;
    req_o.x       = '0;
    req_o.y       = '0;
    unique case (phase_q)
      PH_PREP: begin
        unique case (step_q)
          PS_BMOD: begin
            req_o.wide = 1'b1;
            req_o.x    = wide_t'(b_q);
            req_o.y    = one_q;
          end
          PS_AMOD: begin
            req_o.wide = 1'b1;
            req_o.x    = wide_t'(a_q);
            req_o.y    = one_q;
          end
          PS_S1: begin
            req_o.op = OP_ADD;
            req_o.x  = wide_t'(amod_q);
            req_o.y  = amod_q;
          end
          PS_ASQ: begin
            req_o.x = wide_t'(amod_q);
            req_o.y = amod_q;
          end
          PS_COEF: begin
            req_o.op = OP_SUB;
            req_o.x  = wide_t'(bmod_q);
            req_o.y  = acc_q;
          end
          PS_S2MUL: begin
            req_o.x = wide_t'(s1_q);
            req_o.y = amod_q;
          end
          PS_S2ADD1, PS_S2ADD2: begin
            req_o.op = OP_ADD;
            req_o.x  = wide_t'(s2_q);
            req_o.y  = bmod_q;
          end
          default: begin
            req_o.op = OP_ADD;
          end
        endcase
      end
      PH_MAT: begin
        if (term_q == TM_SUM) begin
          req_o.op = OP_ADD;
          req_o.x  = wide_t'(acc_q);
          req_o.y  = tmp_q;
        end else begin
          req_o.x = wide_t'(left_val);
          req_o.y = right_val;
        end
      end
      PH_FIN: begin
        unique case (term_q)
          TM_FIRST: begin
            req_o.x = wide_t'(q_q[0]);
            req_o.y = s2_q;
          end
          TM_SECOND: begin
            req_o.x = wide_t'(q_q[1]);
            req_o.y = s1_q;
          end
          default: begin
            req_o.op = OP_ADD;
            req_o.x  = wide_t'(acc_q);
            req_o.y  = tmp_q;
          end
        endcase
      end
      default: begin
        req_o.op = OP_ADD;
      end
    endcase
    stat_o.idle      = (state_q == ST_IDLE);
    stat_o.res_valid = (state_q == ST_DONE);
  end

  assign result_o = result_q;

  // control registers: state and step counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_PREP;
      step_q  <= PS_BMOD;
      term_q  <= TM_FIRST;
      elem_q  <= '0;
      sq_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            phase_q <= PH_PREP;
            step_q  <= PS_BMOD;
          end
        end
        ST_WAIT: begin
          if (rsp_i.done) begin
            if (phase_q == PH_PREP) begin
              step_q <= prep_step_e'(step_q + 3'd1);
            end else if (term_q == TM_SUM) begin
              term_q <= TM_FIRST;
              elem_q <= elem_q + 2'd1;
            end else begin
              term_q <= term_e'(term_q + 2'd1);
            end
          end
        end
        ST_LOOP: begin
          term_q  <= TM_FIRST;
          elem_q  <= '0;
          phase_q <= (exp_q == '0) ? PH_FIN : PH_MAT;
          sq_q    <= ~exp_q[0];
        end
        ST_COPY: begin
          term_q <= TM_FIRST;
          elem_q <= '0;
          sq_q   <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          a_q      <= base_a_i;
          b_q      <= radicand_b_i;
          n_q      <= term_index_i;
          m_q      <= m_in;
          one_q    <= (m_in == value_t'(1)) ? '0 : value_t'(1);
          n_le1_q  <= (term_index_i <= IDX_BITS'(1));
          result_q <= '0;
        end
      end
      ST_WAIT: begin
        if (rsp_i.done) begin
          unique case (phase_q)
            PH_PREP: begin
              unique case (step_q)
                PS_BMOD: bmod_q <= rsp_i.result;
                PS_AMOD: amod_q <= rsp_i.result;
                PS_S1: begin
                  s1_q     <= rsp_i.result;
                  result_q <= rsp_i.result;
                end
                PS_ASQ:  acc_q  <= rsp_i.result;
                PS_COEF: p_q[1] <= rsp_i.result;
                PS_S2MUL, PS_S2ADD1: s2_q <= rsp_i.result;
                PS_S2ADD2: begin
                  // second term done: companion matrix and identity in place
                  s2_q   <= rsp_i.result;
                  p_q[0] <= s1_q;
                  p_q[2] <= one_q;
                  p_q[3] <= '0;
                  q_q    <= {one_q, value_t'(0), value_t'(0), one_q};
                  exp_q  <= exp_t'(n_q - IDX_BITS'(2));
                end
                default: begin
                end
              endcase
            end
            PH_MAT: begin
              unique case (term_q)
                TM_FIRST:  acc_q     <= rsp_i.result;
                TM_SECOND: tmp_q     <= rsp_i.result;
                default:   t_q[elem_q] <= rsp_i.result;
              endcase
            end
            PH_FIN: begin
              unique case (term_q)
                TM_FIRST:  acc_q    <= rsp_i.result;
                TM_SECOND: tmp_q    <= rsp_i.result;
                default:   result_q <= rsp_i.result;
              endcase
            end
            default: begin
            end
          endcase
        end
      end
      ST_COPY: begin
        if (sq_q) begin
          p_q   <= t_q;
          exp_q <= exp_q >> 1;
        end else begin
          q_q <= t_q;
        end
      end
      default: begin
      end
    endcase
  end

  `RTBMP_ASSERT(a_result_reduced, clk_i, rst_ni, (state_q != ST_DONE) || (m_q == '0) || (result_q < m_q), "result not below modulus")

endmodule

FILE: src/recurrence_term_by_matrix_power.sv
// Returns S_n mod m of the recurrence S_1 = 2a, S_2 = 2a^2 + 2b,
// S_n = 2a*S_(n-1) + (b - a^2)*S_(n-2), one result per request. The block works on one
// request at a time and is not ready until the sequencer is back in idle; a finished result
// sits in an output register, so the next request is taken while it waits. All arithmetic
// runs on one shared modular unit: a multiply is bit-serial over its operand (the full
// 32-bit width for the two input reductions), an add or subtract is a single step. The run
// time grows with the bit length of n-2 and its number of set bits; n of one or less returns
// after the first term is formed, and a zero modulus skips all arithmetic.
// depends on rtbmp_pkg, rtbmp_modunit and rtbmp_seq
`include "recurrence_term_by_matrix_power_assert.svh"

module recurrence_term_by_matrix_power (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [rtbmp_pkg::A_BITS-1:0]       base_a_i,
  input  logic [rtbmp_pkg::B_BITS-1:0]       radicand_b_i,
  input  logic [rtbmp_pkg::IDX_BITS-1:0]     term_index_i,
  input  logic [rtbmp_pkg::M_BITS-1:0]       modulus_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [rtbmp_pkg::OUT_BITS-1:0]     term_value_o
);
  import rtbmp_pkg::*;

  req_t   req;
  rsp_t   rsp;
  stat_t  stat;
  value_t seq_result;
  logic   start;
  logic   take;

  logic   out_valid_q, out_valid_d;
  value_t term_value_q;

  // request handshake
  assign in_ready_o = stat.idle;
  assign start      = in_valid_i && stat.idle;

  // move a finished result into the output register when it is free
  assign take = stat.res_valid && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      term_value_q <= seq_result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign term_value_o = OUT_BITS'(term_value_q);

  // sequencer and shared arithmetic unit
  rtbmp_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .base_a_i     (base_a_i),
    .radicand_b_i (radicand_b_i),
    .term_index_i (term_index_i),
    .modulus_i    (modulus_i),
    .take_i       (take),
    .stat_o       (stat),
    .result_o     (seq_result),
    .req_o        (req),
    .rsp_i        (rsp)
  );

  rtbmp_modunit u_modunit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  `RTBMP_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "ready right after accepting a request")

endmodule
